// ===== hw/rtl/mee_pkg.sv =====
// Shared types and constants for the MIDI event encoder.
// No dependencies; the core, mee_vlq and mee_seq import this package.
package mee_pkg;

	localparam int DeltaWidth = 28;
	localparam int ParamWidth = 30;

	// Configuration register indexes.
	localparam logic CFG_CHANNEL  = 1'b0;
	localparam logic CFG_RPN_TYPE = 1'b1;

	localparam logic [7:0] CFG_RPN_TYPE_RESET = 8'h07;

	// Event kinds, taken from the upper status nibble.
	localparam logic [3:0] KIND_CTRL_CHANGE = 4'hB;
	localparam logic [3:0] KIND_PROG_CHANGE = 4'hC;
	localparam logic [3:0] KIND_CHAN_PRESS  = 4'hD;

	localparam logic [7:0] STATUS_CC_RAW  = 8'hB0;
	localparam logic [7:0] PARAM_MARK     = 8'hFF;

	// Controller numbers used by the parameter expansion.
	localparam logic [7:0] CC_RPN_MSB     = 8'h65;
	localparam logic [7:0] CC_RPN_LSB     = 8'h64;
	localparam logic [7:0] CC_NRPN_MSB    = 8'h63;
	localparam logic [7:0] CC_NRPN_LSB    = 8'h62;
	localparam logic [7:0] CC_ENTRY_MSB   = 8'h06;
	localparam logic [7:0] CC_ENTRY_LSB   = 8'h26;
	localparam logic [7:0] RUNNING_DELTA  = 8'h00;

	localparam logic [3:0] PARAM_BODY_LAST = 4'd10;

	// One variable-length-quantity byte offered by the group shifter.
	typedef struct packed {
		logic [7:0] data;
		logic       final_grp;
	} vlq_t;

endpackage

// ===== hw/rtl/mee_in_if.sv =====
// Event channel of the MIDI event encoder: valid/ready plus the event fields.
// No dependencies.
interface mee_in_if;
	logic        valid;
	logic        ready;
	logic [27:0] delta_time;
	logic [7:0]  status_byte;
	logic [7:0]  data_one;
	logic [7:0]  data_two;
	logic [29:0] param_data;

	modport source (output valid, delta_time, status_byte, data_one, data_two, param_data,
		input ready);
	modport sink (input valid, delta_time, status_byte, data_one, data_two, param_data,
		output ready);
endinterface

// ===== hw/rtl/mee_out_if.sv =====
// Byte channel of the MIDI event encoder: valid/ready plus one encoded byte.
// No dependencies.
interface mee_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [3:0] byte_index;
	logic       last;

	modport source (output valid, out_byte, byte_index, last, input ready);
	modport sink (input valid, out_byte, byte_index, last, output ready);
endinterface

// ===== hw/rtl/midi_event_encoder_core.sv =====
// Top level of the MIDI event encoder: configuration registers, the byte
// sequencer and the delta group shifter. Depends on mee_pkg, mee_in_if,
// mee_out_if, mee_vlq and mee_seq.
//
//   channel | dir | beat contents
//   --------+-----+--------------------------------------------------------
//   evt     | in  | delta_time, status_byte, data_one, data_two, param_data
//   enc     | out | out_byte, byte_index, last (one encoded byte per beat)
//   cfg     | in  | cfg_we, cfg_index, cfg_data (write only)
//
// An event is accepted and then encoded byte by byte: 1 to 4 delta bytes,
// the status byte and 1, 2 or 11 body bytes, 3 to 16 bytes in all; the byte
// sequencer emits one byte a cycle while the output is not stalled.
// Reset clears the sequencer to idle, empties the output register and loads
// the register defaults (channel 0, RPN type code 7).
// A stalled output freezes the sequencer; the event channel is not ready
// until the last byte of the current event sits in the output register.
module midi_event_encoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	mee_in_if.sink     evt,
	mee_out_if.source  enc
);
	import mee_pkg::*;

	logic [3:0]  channel_q;
	logic [7:0]  rpn_type_q;
	logic        vlq_load;
	logic        vlq_step;
	vlq_t        vlq;

	// Configuration writes must land only while the encoder is idle (the block
	// does not enforce it); the channel is read live, the RPN type at accept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_q  <= 4'd0;
			rpn_type_q <= CFG_RPN_TYPE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CHANNEL:  channel_q  <= cfg_data[3:0];
				CFG_RPN_TYPE: rpn_type_q <= cfg_data;
				default:      channel_q  <= channel_q;
			endcase
		end
	end

	// The group shifter hands the sequencer one delta byte per step, most
	// significant group first, continuation bit set on all but the last byte.
	mee_vlq u_vlq (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (vlq_load),
		.delta  (evt.delta_time),
		.step   (vlq_step),
		.vlq    (vlq)
	);

	// The sequencer owns both handshakes and the output register, which lets
	// the next event be accepted while the final byte still waits downstream.
	mee_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.channel       (channel_q),
		.rpn_type_code (rpn_type_q),
		.evt           (evt),
		.enc           (enc),
		.vlq_load      (vlq_load),
		.vlq_step      (vlq_step),
		.vlq           (vlq)
	);

endmodule

// ===== hw/rtl/mee_vlq.sv =====
// Delta-time group shifter: holds the delta left-aligned on its first group
// and shifts out one 7-bit group per step. Depends on mee_pkg.
module mee_vlq (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  logic [mee_pkg::DeltaWidth-1:0]    delta,
	input  logic                              step,
	output mee_pkg::vlq_t                     vlq
);
	import mee_pkg::*;

	logic [DeltaWidth-1:0] grp_q;
	logic [1:0]            rem_q;

	// Leading zero groups are dropped; a zero delta still keeps one group.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
		end else if (load) begin
			if (|delta[27:21]) begin
				rem_q <= 2'd3;
			end else if (|delta[27:14]) begin
				rem_q <= 2'd2;
			end else if (|delta[27:7]) begin
				rem_q <= 2'd1;
			end else begin
				rem_q <= 2'd0;
			end
		end else if (step && rem_q != 2'd0) begin
			rem_q <= rem_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (|delta[27:21]) begin
				grp_q <= delta;
			end else if (|delta[27:14]) begin
				grp_q <= {delta[20:0], 7'd0};
			end else if (|delta[27:7]) begin
				grp_q <= {delta[13:0], 14'd0};
			end else begin
				grp_q <= {delta[6:0], 21'd0};
			end
		end else if (step) begin
			grp_q <= {grp_q[20:0], 7'd0};
		end
	end

	assign vlq.data      = {(rem_q != 2'd0), grp_q[27:21]};
	assign vlq.final_grp = (rem_q == 2'd0);

endmodule

// ===== hw/rtl/mee_seq.sv =====
// Byte sequencer: walks delta groups, status and data bytes of one event and
// loads them one per unstalled cycle into the output register. Depends on
// mee_pkg, mee_in_if and mee_out_if; drives the mee_vlq group shifter.
module mee_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [3:0]    channel,
	input  logic [7:0]    rpn_type_code,
	mee_in_if.sink        evt,
	mee_out_if.source     enc,
	output logic          vlq_load,
	output logic          vlq_step,
	input  mee_pkg::vlq_t vlq
);
	import mee_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_DELTA, ST_STATUS, ST_BODY} state_t;

	state_t          state_q;
	logic [3:0]      kind_q;
	logic [7:0]      d1_q;
	logic [7:0]      d2_q;
	logic [ParamWidth-1:0] pd_q;
	logic            is_param_q;
	logic            is_short_q;
	logic            rpn_q;
	logic [3:0]      body_q;
	logic [3:0]      cnt_q;
	logic [7:0]      out_byte_q;
	logic [3:0]      idx_q;
	logic            last_q;
	logic            out_valid_q;

	logic            advance;
	logic            load_byte;
	logic            accept;
	logic            body_last;
	logic [7:0]      body_byte;
	logic [3:0]      in_kind;

	assign in_kind  = evt.status_byte[7:4];
	assign advance  = !out_valid_q || enc.ready;
	assign load_byte = advance && (state_q != ST_IDLE);
	assign evt.ready = (state_q == ST_IDLE);
	assign accept   = evt.valid && evt.ready;
	assign vlq_load = accept;
	assign vlq_step = (state_q == ST_DELTA) && advance;

	always_comb begin
		body_byte = d1_q;
		if (is_param_q) begin
			case (body_q)
				4'd0:    body_byte = rpn_q ? CC_RPN_MSB : CC_NRPN_MSB;
				4'd1:    body_byte = {1'b0, pd_q[29:23]};
				4'd2:    body_byte = RUNNING_DELTA;
				4'd3:    body_byte = rpn_q ? CC_RPN_LSB : CC_NRPN_LSB;
				4'd4:    body_byte = {1'b0, pd_q[22:16]};
				4'd5:    body_byte = RUNNING_DELTA;
				4'd6:    body_byte = CC_ENTRY_MSB;
				4'd7:    body_byte = {1'b0, pd_q[13:7]};
				4'd8:    body_byte = RUNNING_DELTA;
				4'd9:    body_byte = CC_ENTRY_LSB;
				default: body_byte = {1'b0, pd_q[6:0]};
			endcase
		end else if (body_q != 4'd0) begin
			body_byte = d2_q;
		end
	end

	always_comb begin
		if (is_param_q) begin
			body_last = (body_q == PARAM_BODY_LAST);
		end else if (is_short_q) begin
			body_last = 1'b1;
		end else begin
			body_last = (body_q == 4'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= 4'd0;
			body_q      <= 4'd0;
		end else begin
			// A taken beat empties the register unless the next byte replaces it.
			if (enc.ready && !load_byte) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q   <= 4'd0;
						state_q <= ST_DELTA;
					end
				end
				ST_DELTA: begin
					if (advance) begin
						out_byte_q  <= vlq.data;
						idx_q       <= cnt_q;
						last_q      <= 1'b0;
						out_valid_q <= 1'b1;
						cnt_q       <= cnt_q + 4'd1;
						if (vlq.final_grp) begin
							state_q <= ST_STATUS;
						end
					end
				end
				ST_STATUS: begin
					if (advance) begin
						out_byte_q  <= {kind_q, channel};
						idx_q       <= cnt_q;
						last_q      <= 1'b0;
						out_valid_q <= 1'b1;
						cnt_q       <= cnt_q + 4'd1;
						body_q      <= 4'd0;
						state_q     <= ST_BODY;
					end
				end
				ST_BODY: begin
					if (advance) begin
						out_byte_q  <= body_byte;
						idx_q       <= cnt_q;
						last_q      <= body_last;
						out_valid_q <= 1'b1;
						cnt_q       <= cnt_q + 4'd1;
						body_q      <= body_q + 4'd1;
						if (body_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Event fields are captured once at acceptance and held for the whole event.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q     <= in_kind;
			d1_q       <= evt.data_one;
			d2_q       <= evt.data_two;
			pd_q       <= evt.param_data;
			is_param_q <= (evt.status_byte == STATUS_CC_RAW) && (evt.data_one == PARAM_MARK);
			is_short_q <= (in_kind == KIND_PROG_CHANGE) || (in_kind == KIND_CHAN_PRESS);
			rpn_q      <= (evt.data_two == rpn_type_code);
		end
	end

	assign enc.valid      = out_valid_q;
	assign enc.out_byte   = out_byte_q;
	assign enc.byte_index = idx_q;
	assign enc.last       = last_q;

	// Within an event, beats follow back to back with consecutive indexes.
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && enc.ready && !last_q |=> out_valid_q && idx_q == $past(idx_q) + 4'd1)
		else $error("byte index did not advance by one within an event");

	// The shortest event is one delta byte, the status byte and one data byte.
	a_last_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && last_q |-> idx_q >= 4'd2)
		else $error("event ended before its status and data bytes");

	// An accepted event always starts with its delta bytes.
	a_accept_delta: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_DELTA)
		else $error("accepted event did not start with the delta");

	// A parameter event ends only on the eleventh body byte.
	a_param_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BODY && advance && is_param_q && body_q != PARAM_BODY_LAST
		|=> !last_q)
		else $error("parameter expansion ended early");

endmodule
